### sv/dbcw_pkg.sv
// Shared types, constants and width helpers for the block clip-to-window stage.
// No dependencies; every other file of the block imports this package.
package dbcw_pkg;

	localparam int WIN_W = 11;
	localparam int OFS_W = 12;
	localparam int CH_W = 8;
	localparam int AREA_W = 23;
	localparam int CFG_W = 12;
	localparam int REG_IDX_W = 3;

	localparam int LINE_BUF_PIXELS_DEF = 256;
	localparam int COORD_BITS_DEF = 12;
	localparam int Q_DEPTH = 4;

	localparam logic [CH_W-1:0] CH_MASK = 8'hFC;

	localparam logic [WIN_W-1:0] WIN_LEFT_RST = 11'd0;
	localparam logic [WIN_W-1:0] WIN_TOP_RST = 11'd0;
	localparam logic [WIN_W-1:0] WIN_RIGHT_RST = 11'd319;
	localparam logic [WIN_W-1:0] WIN_BOTTOM_RST = 11'd239;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_WIN_LEFT = 3'd0,
		REG_WIN_TOP = 3'd1,
		REG_WIN_RIGHT = 3'd2,
		REG_WIN_BOTTOM = 3'd3,
		REG_OFFSET_X = 3'd4,
		REG_OFFSET_Y = 3'd5
	} reg_idx_t;

	typedef enum logic [1:0] {
		KIND_PIXEL = 2'd0,
		KIND_SENT = 2'd1,
		KIND_OFF = 2'd2,
		KIND_BIG = 2'd3
	} kind_t;

	typedef struct packed {
		logic [WIN_W-1:0] win_left;
		logic [WIN_W-1:0] win_top;
		logic [WIN_W-1:0] win_right;
		logic [WIN_W-1:0] win_bottom;
		logic signed [OFS_W-1:0] offset_x;
		logic signed [OFS_W-1:0] offset_y;
	} cfg_t;

	// Signed width that holds a tag plus an in-block counter plus the offset.
	function automatic int sum_width(input int cb);
		return ((cb > OFS_W) ? cb : OFS_W) + 3;
	endfunction

	// Width of one queued request: two flags, six coordinates, three channels.
	function automatic int qitem_width(input int cb);
		return 2 + 6 * sum_width(cb) + 3 * CH_W;
	endfunction

endpackage

### sv/decoded_block_clip_to_window_top.sv
// Top level of the block clip-to-window stage.
// Instantiates dbcw_cfg, dbcw_front, dbcw_fifo and dbcw_back; uses dbcw_pkg.
//
// Usage:
// Pixels of a decoded block enter in row order on the input channel
// (in_valid / in_stall), each tagged with the block's image rectangle.
// Results leave on the output channel (out_valid / out_stall): a visible
// pixel (kind 0) with its screen position, and at a block's last pixel one
// block-end report (sent, off screen, or too large).
// The window and the image offset are written through cfg_we, cfg_index and
// cfg_data while no request is in flight.
// An accepted pixel passes through the request queue, three clipping stages
// and the output register before its result appears.
// One pixel is taken per cycle while in_stall is low. A last pixel that is
// also visible yields two results, the pixel first and then the block end.
// A stall on the output holds the result in place; the back end stops and
// the four-entry request queue fills before in_stall rises.
// Reset restores the default 320 by 240 window, a zero offset, buffer
// select zero, and empties the queue and all stages.
module decoded_block_clip_to_window_top import dbcw_pkg::*; #(
	parameter int LINE_BUF_PIXELS = LINE_BUF_PIXELS_DEF,
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [REG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]      cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [COORD_BITS-1:0] blk_left,
	input  logic [COORD_BITS-1:0] blk_top,
	input  logic [COORD_BITS-1:0] blk_right,
	input  logic [COORD_BITS-1:0] blk_bottom,
	input  logic [CH_W-1:0]       red,
	input  logic [CH_W-1:0]       green,
	input  logic [CH_W-1:0]       blue,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [1:0]            kind,
	output logic [CH_W-1:0]       out_red,
	output logic [CH_W-1:0]       out_green,
	output logic [CH_W-1:0]       out_blue,
	output logic [WIN_W-1:0]      dst_x,
	output logic [WIN_W-1:0]      dst_y,
	output logic [WIN_W-1:0]      clip_left,
	output logic [WIN_W-1:0]      clip_top,
	output logic [WIN_W-1:0]      clip_right,
	output logic [WIN_W-1:0]      clip_bottom,
	output logic [AREA_W-1:0]     pixel_count,
	output logic                  buffer_select
);

	localparam int QW = qitem_width(COORD_BITS);

	cfg_t          cfg;
	logic          q_push;
	logic          q_pop;
	logic          q_full;
	logic          q_valid;
	logic [QW-1:0] q_wdata;
	logic [QW-1:0] q_rdata;

	assign in_stall = q_full;

	dbcw_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	dbcw_front #(
		.COORD_BITS (COORD_BITS),
		.QW         (QW)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.in_valid   (in_valid),
		.blk_left   (blk_left),
		.blk_top    (blk_top),
		.blk_right  (blk_right),
		.blk_bottom (blk_bottom),
		.red        (red),
		.green      (green),
		.blue       (blue),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_data     (q_wdata)
	);

	dbcw_fifo #(
		.WIDTH (QW),
		.DEPTH (Q_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.pop    (q_pop),
		.full   (q_full),
		.valid  (q_valid),
		.rdata  (q_rdata)
	);

	dbcw_back #(
		.COORD_BITS      (COORD_BITS),
		.LINE_BUF_PIXELS (LINE_BUF_PIXELS),
		.QW              (QW)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.q_valid       (q_valid),
		.q_data        (q_rdata),
		.q_pop         (q_pop),
		.out_stall     (out_stall),
		.out_valid     (out_valid),
		.kind          (kind),
		.out_red       (out_red),
		.out_green     (out_green),
		.out_blue      (out_blue),
		.dst_x         (dst_x),
		.dst_y         (dst_y),
		.clip_left     (clip_left),
		.clip_top      (clip_top),
		.clip_right    (clip_right),
		.clip_bottom   (clip_bottom),
		.pixel_count   (pixel_count),
		.buffer_select (buffer_select)
	);

endmodule

### sv/dbcw_cfg.sv
// Configuration register file: display window and image offset.
// Depends on dbcw_pkg for the register index codes and the cfg_t bundle.
module dbcw_cfg import dbcw_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	output cfg_t                 cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.win_left <= WIN_LEFT_RST;
			cfg_q.win_top <= WIN_TOP_RST;
			cfg_q.win_right <= WIN_RIGHT_RST;
			cfg_q.win_bottom <= WIN_BOTTOM_RST;
			cfg_q.offset_x <= '0;
			cfg_q.offset_y <= '0;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_WIN_LEFT: cfg_q.win_left <= cfg_data[WIN_W-1:0];
				REG_WIN_TOP: cfg_q.win_top <= cfg_data[WIN_W-1:0];
				REG_WIN_RIGHT: cfg_q.win_right <= cfg_data[WIN_W-1:0];
				REG_WIN_BOTTOM: cfg_q.win_bottom <= cfg_data[WIN_W-1:0];
				REG_OFFSET_X: cfg_q.offset_x <= $signed(cfg_data[OFS_W-1:0]);
				REG_OFFSET_Y: cfg_q.offset_y <= $signed(cfg_data[OFS_W-1:0]);
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### sv/dbcw_front.sv
// Front end: accepts pixels, tracks the position inside the block and marks
// first and last pixels. Depends on dbcw_pkg; feeds the request queue.
module dbcw_front import dbcw_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF,
	parameter int QW = qitem_width(COORD_BITS_DEF)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cfg_t                  cfg,
	input  logic                  in_valid,
	input  logic [COORD_BITS-1:0] blk_left,
	input  logic [COORD_BITS-1:0] blk_top,
	input  logic [COORD_BITS-1:0] blk_right,
	input  logic [COORD_BITS-1:0] blk_bottom,
	input  logic [CH_W-1:0]       red,
	input  logic [CH_W-1:0]       green,
	input  logic [CH_W-1:0]       blue,
	input  logic                  q_full,
	output logic                  q_push,
	output logic [QW-1:0]         q_data
);

	localparam int SW = sum_width(COORD_BITS);

	typedef struct packed {
		logic first;
		logic last;
		logic signed [SW-1:0] l;
		logic signed [SW-1:0] t;
		logic signed [SW-1:0] r;
		logic signed [SW-1:0] b;
		logic signed [SW-1:0] x;
		logic signed [SW-1:0] y;
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
	} qitem_t;

	logic [COORD_BITS-1:0] col_q;
	logic [COORD_BITS-1:0] row_q;
	logic                  first_q;
	logic [COORD_BITS:0]   col_sum;
	logic [COORD_BITS:0]   row_sum;
	logic                  row_end;
	logic                  last;
	logic signed [SW-1:0]  ox;
	logic signed [SW-1:0]  oy;
	qitem_t                item;

	always_comb begin
		col_sum = {1'b0, blk_left} + {1'b0, col_q};
		row_sum = {1'b0, blk_top} + {1'b0, row_q};
		row_end = col_sum >= {1'b0, blk_right};
		last = row_end && (row_sum >= {1'b0, blk_bottom});
		ox = {{(SW-OFS_W){cfg.offset_x[OFS_W-1]}}, cfg.offset_x};
		oy = {{(SW-OFS_W){cfg.offset_y[OFS_W-1]}}, cfg.offset_y};
		item.first = first_q;
		item.last = last;
		item.l = $signed(SW'(blk_left)) + ox;
		item.t = $signed(SW'(blk_top)) + oy;
		item.r = $signed(SW'(blk_right)) + ox;
		item.b = $signed(SW'(blk_bottom)) + oy;
		item.x = item.l + $signed(SW'(col_q));
		item.y = item.t + $signed(SW'(row_q));
		item.red = red & CH_MASK;
		item.green = green & CH_MASK;
		item.blue = blue & CH_MASK;
	end

	assign q_push = in_valid && !q_full;
	assign q_data = item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			first_q <= 1'b1;
		end else if (q_push) begin
			if (last) begin
				col_q <= '0;
				row_q <= '0;
				first_q <= 1'b1;
			end else if (row_end) begin
				col_q <= '0;
				row_q <= row_q + 1'b1;
				first_q <= 1'b0;
			end else begin
				col_q <= col_q + 1'b1;
				first_q <= 1'b0;
			end
		end
	end

endmodule

### sv/dbcw_fifo.sv
// Short request queue between the front end and the clipping back end.
// Generic width and depth; no package dependencies beyond the import.
module dbcw_fifo import dbcw_pkg::*; #(
	parameter int WIDTH = qitem_width(COORD_BITS_DEF),
	parameter int DEPTH = Q_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic             full,
	output logic             valid,
	output logic [WIDTH-1:0] rdata
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;

	assign full = count_q == CW'(DEPTH);
	assign valid = count_q != '0;
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: ;
			endcase
		end
	end

endmodule

### sv/dbcw_back.sv
// Back end: clips each block rectangle to the window over three stages,
// latches it at the block's first pixel and issues pixel and block-end results.
// Depends on dbcw_pkg; takes requests from dbcw_fifo.
module dbcw_back import dbcw_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF,
	parameter int LINE_BUF_PIXELS = LINE_BUF_PIXELS_DEF,
	parameter int QW = qitem_width(COORD_BITS_DEF)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cfg_t              cfg,
	input  logic              q_valid,
	input  logic [QW-1:0]     q_data,
	output logic              q_pop,
	input  logic              out_stall,
	output logic              out_valid,
	output logic [1:0]        kind,
	output logic [CH_W-1:0]   out_red,
	output logic [CH_W-1:0]   out_green,
	output logic [CH_W-1:0]   out_blue,
	output logic [WIN_W-1:0]  dst_x,
	output logic [WIN_W-1:0]  dst_y,
	output logic [WIN_W-1:0]  clip_left,
	output logic [WIN_W-1:0]  clip_top,
	output logic [WIN_W-1:0]  clip_right,
	output logic [WIN_W-1:0]  clip_bottom,
	output logic [AREA_W-1:0] pixel_count,
	output logic              buffer_select
);

	localparam int SW = sum_width(COORD_BITS);
	localparam logic [AREA_W:0] LBP = (AREA_W+1)'(LINE_BUF_PIXELS);
	localparam logic signed [SW-1:0] ONE = SW'(1);

	typedef struct packed {
		logic first;
		logic last;
		logic signed [SW-1:0] l;
		logic signed [SW-1:0] t;
		logic signed [SW-1:0] r;
		logic signed [SW-1:0] b;
		logic signed [SW-1:0] x;
		logic signed [SW-1:0] y;
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
	} qitem_t;

	typedef struct packed {
		logic first;
		logic last;
		logic signed [SW-1:0] x;
		logic signed [SW-1:0] y;
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
	} pix_t;

	typedef struct packed {
		logic [WIN_W-1:0] left;
		logic [WIN_W-1:0] top;
		logic [WIN_W-1:0] right;
		logic [WIN_W-1:0] bottom;
	} rect_t;

	typedef struct packed {
		pix_t pix;
		logic off;
		logic signed [SW-1:0] dl;
		logic signed [SW-1:0] dt;
		logic signed [SW-1:0] dr;
		logic signed [SW-1:0] db;
	} s1_t;

	typedef struct packed {
		pix_t pix;
		logic off;
		rect_t rect;
		logic wpos;
		logic hpos;
		logic [WIN_W:0] w;
		logic [WIN_W:0] h;
	} s2_t;

	typedef struct packed {
		pix_t pix;
		logic off;
		rect_t rect;
		logic wpos;
		logic hpos;
		logic [AREA_W-1:0] area;
	} s3_t;

	qitem_t qi;
	s1_t    d_s1, n_s1;
	s2_t    d_s2, n_s2;
	s3_t    d_s3, n_s3;
	logic   v_s1, v_s2, v_s3;
	logic   rdy1, rdy2, rdy3;

	logic signed [SW-1:0] x1, y1, x2, y2;
	logic signed [SW-1:0] w_full, h_full;
	logic [2*(WIN_W+1)-1:0] prod;

	kind_t             cls_q;
	rect_t             rect_q;
	logic [AREA_W-1:0] cnt_q;
	logic              tog_q;

	kind_t             cls_new, eff_cls;
	rect_t             eff_rect;
	logic [AREA_W-1:0] cnt_new, eff_cnt;
	logic              vis;
	logic              keep_rect;

	logic              pix_pend_q, end_pend_q;
	logic              out_acc, load_ok, load;
	logic [CH_W-1:0]   pix_r_q, pix_g_q, pix_b_q;
	logic [WIN_W-1:0]  pix_x_q, pix_y_q;
	kind_t             end_kind_q;
	rect_t             end_rect_q;
	logic [AREA_W-1:0] end_cnt_q;
	logic              end_bsel_q;

	assign qi = q_data;
	assign x1 = $signed(SW'(cfg.win_left));
	assign y1 = $signed(SW'(cfg.win_top));
	assign x2 = $signed(SW'(cfg.win_right));
	assign y2 = $signed(SW'(cfg.win_bottom));

	// Stage 1: off-screen test on the shifted rectangle and clamping.
	always_comb begin
		n_s1.pix.first = qi.first;
		n_s1.pix.last = qi.last;
		n_s1.pix.x = qi.x;
		n_s1.pix.y = qi.y;
		n_s1.pix.red = qi.red;
		n_s1.pix.green = qi.green;
		n_s1.pix.blue = qi.blue;
		n_s1.off = (qi.l > x2) || (qi.t > y2) || (qi.r < x1) || (qi.b < y1);
		n_s1.dl = (qi.l < x1) ? x1 : qi.l;
		n_s1.dt = (qi.t < y1) ? y1 : qi.t;
		n_s1.dr = (qi.r > x2) ? x2 : qi.r;
		n_s1.db = (qi.b > y2) ? y2 : qi.b;
	end

	// Stage 2: recheck against an inverted window and form the extents.
	always_comb begin
		w_full = d_s1.dr - d_s1.dl + ONE;
		h_full = d_s1.db - d_s1.dt + ONE;
		n_s2.pix = d_s1.pix;
		n_s2.off = d_s1.off || (d_s1.dl > x2) || (d_s1.dt > y2) ||
			(d_s1.dr < x1) || (d_s1.db < y1);
		n_s2.rect.left = d_s1.dl[WIN_W-1:0];
		n_s2.rect.top = d_s1.dt[WIN_W-1:0];
		n_s2.rect.right = d_s1.dr[WIN_W-1:0];
		n_s2.rect.bottom = d_s1.db[WIN_W-1:0];
		n_s2.wpos = w_full > 0;
		n_s2.hpos = h_full > 0;
		n_s2.w = w_full[WIN_W:0];
		n_s2.h = h_full[WIN_W:0];
	end

	// Stage 3: area of the clipped rectangle.
	always_comb begin
		prod = {{(WIN_W+1){1'b0}}, d_s2.w} * {{(WIN_W+1){1'b0}}, d_s2.h};
		n_s3.pix = d_s2.pix;
		n_s3.off = d_s2.off;
		n_s3.rect = d_s2.rect;
		n_s3.wpos = d_s2.wpos;
		n_s3.hpos = d_s2.hpos;
		n_s3.area = prod[AREA_W-1:0];
	end

	// Result stage: classify, pick the latched or fresh rectangle, test visibility.
	always_comb begin
		cnt_new = (d_s3.wpos && d_s3.hpos) ? d_s3.area : '0;
		if (d_s3.off) begin
			cls_new = KIND_OFF;
		end else if (!(d_s3.wpos && d_s3.hpos)) begin
			cls_new = KIND_BIG;
		end else if ({1'b0, d_s3.area} > LBP) begin
			cls_new = KIND_BIG;
		end else begin
			cls_new = KIND_SENT;
		end
		eff_cls = d_s3.pix.first ? cls_new : cls_q;
		eff_rect = d_s3.pix.first ? (d_s3.off ? '0 : d_s3.rect) : rect_q;
		eff_cnt = d_s3.pix.first ? cnt_new : cnt_q;
		keep_rect = (eff_cls == KIND_SENT) || (eff_cls == KIND_BIG);
		vis = (eff_cls == KIND_SENT) &&
			(d_s3.pix.x >= $signed(SW'(eff_rect.left))) &&
			(d_s3.pix.x <= $signed(SW'(eff_rect.right))) &&
			(d_s3.pix.y >= $signed(SW'(eff_rect.top))) &&
			(d_s3.pix.y <= $signed(SW'(eff_rect.bottom)));
	end

	assign out_valid = pix_pend_q || end_pend_q;
	assign out_acc = out_valid && !out_stall;
	assign load_ok = !out_valid || (out_acc && !(pix_pend_q && end_pend_q));
	assign load = v_s3 && load_ok;
	assign rdy3 = !v_s3 || load_ok;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;
	assign q_pop = q_valid && rdy1;

	always_ff @(posedge clk) begin
		if (rdy1) begin
			d_s1 <= n_s1;
		end
		if (rdy2) begin
			d_s2 <= n_s2;
		end
		if (rdy3) begin
			d_s3 <= n_s3;
		end
		if (load) begin
			pix_r_q <= d_s3.pix.red;
			pix_g_q <= d_s3.pix.green;
			pix_b_q <= d_s3.pix.blue;
			pix_x_q <= d_s3.pix.x[WIN_W-1:0];
			pix_y_q <= d_s3.pix.y[WIN_W-1:0];
			end_kind_q <= eff_cls;
			end_rect_q <= keep_rect ? eff_rect : '0;
			end_cnt_q <= keep_rect ? eff_cnt : '0;
			end_bsel_q <= (eff_cls == KIND_SENT) ? tog_q : 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			pix_pend_q <= 1'b0;
			end_pend_q <= 1'b0;
			cls_q <= KIND_PIXEL;
			rect_q <= '0;
			cnt_q <= '0;
			tog_q <= 1'b0;
		end else begin
			if (rdy1) begin
				v_s1 <= q_valid;
			end
			if (rdy2) begin
				v_s2 <= v_s1;
			end
			if (rdy3) begin
				v_s3 <= v_s2;
			end
			if (load) begin
				pix_pend_q <= vis;
				end_pend_q <= d_s3.pix.last;
				if (d_s3.pix.first) begin
					cls_q <= cls_new;
					rect_q <= eff_rect;
					cnt_q <= cnt_new;
				end
				if (d_s3.pix.last && eff_cls == KIND_SENT) begin
					tog_q <= ~tog_q;
				end
			end else if (out_acc) begin
				if (pix_pend_q) begin
					pix_pend_q <= 1'b0;
				end else begin
					end_pend_q <= 1'b0;
				end
			end
		end
	end

	assign kind = pix_pend_q ? KIND_PIXEL : end_kind_q;
	assign out_red = pix_pend_q ? pix_r_q : '0;
	assign out_green = pix_pend_q ? pix_g_q : '0;
	assign out_blue = pix_pend_q ? pix_b_q : '0;
	assign dst_x = pix_pend_q ? pix_x_q : '0;
	assign dst_y = pix_pend_q ? pix_y_q : '0;
	assign clip_left = pix_pend_q ? '0 : end_rect_q.left;
	assign clip_top = pix_pend_q ? '0 : end_rect_q.top;
	assign clip_right = pix_pend_q ? '0 : end_rect_q.right;
	assign clip_bottom = pix_pend_q ? '0 : end_rect_q.bottom;
	assign pixel_count = pix_pend_q ? '0 : end_cnt_q;
	assign buffer_select = pix_pend_q ? 1'b0 : end_bsel_q;

	a_pix_in_rect: assert property (@(posedge clk) disable iff (!arst_n)
		pix_pend_q |-> (cls_q == KIND_SENT) &&
			(pix_x_q >= rect_q.left) && (pix_x_q <= rect_q.right) &&
			(pix_y_q >= rect_q.top) && (pix_y_q <= rect_q.bottom))
		else $error("Visible pixel outside the latched clipped rectangle.");

	a_toggle_on_send: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(tog_q) |-> (end_pend_q && end_kind_q == KIND_SENT))
		else $error("Buffer select toggled without a sent block end.");

	a_off_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(end_pend_q && end_kind_q == KIND_OFF) |->
			(end_cnt_q == '0) && !end_bsel_q)
		else $error("Off-screen block end carries a count or buffer select.");

	a_sent_fits: assert property (@(posedge clk) disable iff (!arst_n)
		(end_pend_q && end_kind_q == KIND_SENT) |->
			(end_cnt_q != '0) && ({1'b0, end_cnt_q} <= LBP))
		else $error("Sent block does not fit the line buffer.");

endmodule

### sim/decoded_block_clip_to_window_top_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for decoded_block_clip_to_window_top: it streams pixel blocks
// under several window and offset settings and checks every result in order against
// its own prediction. Depends on dbcw_pkg and the RTL of the block only.
module decoded_block_clip_to_window_top_test;
	import dbcw_pkg::*;

	localparam int CB = COORD_BITS_DEF;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int HOLD_CYCLES = 300;
	localparam int SETTLE_CYCLES = 10;
	localparam int ITEM_TARGET = 1800;
	localparam int RANDOM_PHASES = 6;
	localparam int MAX_REPORTS = 100;

	typedef enum logic [1:0] {MODE_IDLE, MODE_SEND, MODE_SKIP, MODE_BIG} blk_mode_t;
	typedef enum {STALL_NONE, STALL_RANDOM, STALL_RUNS} stall_kind_t;

	typedef struct packed {
		logic [CB-1:0]   left;
		logic [CB-1:0]   top;
		logic [CB-1:0]   right;
		logic [CB-1:0]   bottom;
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
	} pixel_t;

	typedef struct packed {
		kind_t             kind;
		logic [CH_W-1:0]   red;
		logic [CH_W-1:0]   green;
		logic [CH_W-1:0]   blue;
		logic [WIN_W-1:0]  dst_x;
		logic [WIN_W-1:0]  dst_y;
		logic [WIN_W-1:0]  clip_left;
		logic [WIN_W-1:0]  clip_top;
		logic [WIN_W-1:0]  clip_right;
		logic [WIN_W-1:0]  clip_bottom;
		logic [AREA_W-1:0] pixel_count;
		logic              buffer_select;
	} clip_result_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [REG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;
	logic                 in_valid;
	logic                 in_stall;
	logic [CB-1:0]        blk_left, blk_top, blk_right, blk_bottom;
	logic [CH_W-1:0]      red, green, blue;
	logic                 out_valid;
	logic                 out_stall;
	logic [1:0]           kind;
	logic [CH_W-1:0]      out_red, out_green, out_blue;
	logic [WIN_W-1:0]     dst_x, dst_y;
	logic [WIN_W-1:0]     clip_left, clip_top, clip_right, clip_bottom;
	logic [AREA_W-1:0]    pixel_count;
	logic                 buffer_select;

	// Shadow of the window registers and of the block state.
	logic [WIN_W-1:0]        win_l, win_t, win_r, win_b;
	logic signed [OFS_W-1:0] ofs_x, ofs_y;
	logic [CB-1:0]           blk_col, blk_row;
	int                      rect [4];
	blk_mode_t               blk_mode;
	logic                    buf_sel;

	clip_result_t pending_results [$];

	int          errors = 0;
	int          items_sent = 0;
	int          quiet_cycles = 0;
	int          burst_left = 0;
	bit          gaps_on = 1'b0;
	bit          hold_req = 1'b0;
	stall_kind_t stall_style = STALL_NONE;

	decoded_block_clip_to_window_top dut (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic void open_block(input int l, input int t, input int r, input int b);
		int x1, y1, x2, y2, dl, dt, dr, db, w, h;
		x1 = int'(win_l);
		y1 = int'(win_t);
		x2 = int'(win_r);
		y2 = int'(win_b);
		rect = '{0, 0, 0, 0};
		if (l > x2 || t > y2 || r < x1 || b < y1) begin
			blk_mode = MODE_SKIP;
			return;
		end
		dl = (l < x1) ? x1 : l;
		dt = (t < y1) ? y1 : t;
		dr = (r > x2) ? x2 : r;
		db = (b > y2) ? y2 : b;
		if (dl > x2 || dt > y2 || dr < x1 || db < y1) begin
			blk_mode = MODE_SKIP;
			return;
		end
		rect = '{dl & 'h7FF, dt & 'h7FF, dr & 'h7FF, db & 'h7FF};
		w = dr - dl + 1;
		h = db - dt + 1;
		if (w <= 0 || h <= 0)
			blk_mode = MODE_BIG;
		else
			blk_mode = (w * h > LINE_BUF_PIXELS_DEF) ? MODE_BIG : MODE_SEND;
	endfunction

	function automatic void predict_clip(input pixel_t p);
		int bl, bt, br, bb, ox, oy, col, row, x, y, w, h;
		bit row_end, last;
		clip_result_t res;
		bl = int'(p.left);
		bt = int'(p.top);
		br = int'(p.right);
		bb = int'(p.bottom);
		ox = int'(ofs_x);
		oy = int'(ofs_y);
		if (blk_mode == MODE_IDLE)
			open_block(bl + ox, bt + oy, br + ox, bb + oy);
		col = int'(blk_col);
		row = int'(blk_row);
		x = bl + ox + col;
		y = bt + oy + row;
		if (blk_mode == MODE_SEND && x >= rect[0] && x <= rect[2] &&
				y >= rect[1] && y <= rect[3]) begin
			res = '0;
			res.kind = KIND_PIXEL;
			res.red = p.red & CH_MASK;
			res.green = p.green & CH_MASK;
			res.blue = p.blue & CH_MASK;
			res.dst_x = x[WIN_W-1:0];
			res.dst_y = y[WIN_W-1:0];
			pending_results.push_back(res);
		end
		row_end = (bl + col >= br);
		last = row_end && (bt + row >= bb);
		if (last) begin
			res = '0;
			res.kind = kind_t'(blk_mode);
			if (blk_mode == MODE_SEND || blk_mode == MODE_BIG) begin
				w = rect[2] - rect[0] + 1;
				h = rect[3] - rect[1] + 1;
				res.clip_left = WIN_W'(rect[0]);
				res.clip_top = WIN_W'(rect[1]);
				res.clip_right = WIN_W'(rect[2]);
				res.clip_bottom = WIN_W'(rect[3]);
				if (w > 0 && h > 0)
					res.pixel_count = AREA_W'(w * h);
			end
			if (blk_mode == MODE_SEND) begin
				res.buffer_select = buf_sel;
				buf_sel = ~buf_sel;
			end
			pending_results.push_back(res);
			blk_mode = MODE_IDLE;
			blk_col = '0;
			blk_row = '0;
		end else if (row_end) begin
			blk_col = '0;
			blk_row = blk_row + 1'b1;
		end else begin
			blk_col = blk_col + 1'b1;
		end
	endfunction

	function automatic pixel_t make_pixel(input int l, input int t, input int r, input int b,
			input logic [CH_W-1:0] rd, input logic [CH_W-1:0] gr, input logic [CH_W-1:0] bu);
		pixel_t p;
		p.left = l[CB-1:0];
		p.top = t[CB-1:0];
		p.right = r[CB-1:0];
		p.bottom = b[CB-1:0];
		p.red = rd;
		p.green = gr;
		p.blue = bu;
		return p;
	endfunction

	function automatic pixel_t rand_pixel(input int l, input int t, input int r, input int b);
		return make_pixel(l, t, r, b, CH_W'($urandom_range(0, 255)),
			CH_W'($urandom_range(0, 255)), CH_W'($urandom_range(0, 255)));
	endfunction

	function automatic void check_field(input string name, input int want, input int got);
		if (want != got) begin
			errors++;
			if (errors <= MAX_REPORTS)
				$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
		end
	endfunction

	// A request is taken at an edge where valid is high and stall is low.
	task automatic send_pixel(input pixel_t p);
		int gap;
		if (gaps_on && burst_left == 0) begin
			gap = $urandom_range(0, 12);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		if (burst_left > 0)
			burst_left--;
		in_valid <= 1'b1;
		blk_left <= p.left;
		blk_top <= p.top;
		blk_right <= p.right;
		blk_bottom <= p.bottom;
		red <= p.red;
		green <= p.green;
		blue <= p.blue;
		do @(posedge clk); while (in_stall);
		predict_clip(p);
		items_sent++;
	endtask

	task automatic send_block(input int l, input int t, input int r, input int b);
		int cols, rows;
		cols = (r >= l) ? r - l + 1 : 1;
		rows = (b >= t) ? b - t + 1 : 1;
		for (int ri = 0; ri < rows; ri++)
			for (int ci = 0; ci < cols; ci++)
				send_pixel(rand_pixel(l, t, r, b));
	endtask

	// The first pixel fixes the clipped rectangle; an all-zero tag then ends the block.
	task automatic send_retagged(input int l, input int t, input int r, input int b);
		send_pixel(rand_pixel(l, t, r, b));
		send_pixel(rand_pixel(0, 0, 0, 0));
	endtask

	task automatic drain();
		if (blk_mode != MODE_IDLE)
			send_pixel(rand_pixel(0, 0, 0, 0));
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic configure(input int wl, input int wt, input int wr, input int wb,
			input int ox, input int oy);
		reg_idx_t reg_order [6] = '{REG_WIN_LEFT, REG_WIN_TOP, REG_WIN_RIGHT,
			REG_WIN_BOTTOM, REG_OFFSET_X, REG_OFFSET_Y};
		logic [CFG_W-1:0] vals [6];
		drain();
		vals[0] = {1'($urandom_range(0, 1)), wl[WIN_W-1:0]};
		vals[1] = {1'($urandom_range(0, 1)), wt[WIN_W-1:0]};
		vals[2] = {1'($urandom_range(0, 1)), wr[WIN_W-1:0]};
		vals[3] = {1'($urandom_range(0, 1)), wb[WIN_W-1:0]};
		vals[4] = ox[CFG_W-1:0];
		vals[5] = oy[CFG_W-1:0];
		for (int i = 0; i < 6; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= reg_order[i];
			cfg_data <= vals[i];
			@(posedge clk);
			case (reg_order[i])
				REG_WIN_LEFT: win_l = vals[i][WIN_W-1:0];
				REG_WIN_TOP: win_t = vals[i][WIN_W-1:0];
				REG_WIN_RIGHT: win_r = vals[i][WIN_W-1:0];
				REG_WIN_BOTTOM: win_b = vals[i][WIN_W-1:0];
				REG_OFFSET_X: ofs_x = vals[i];
				REG_OFFSET_Y: ofs_y = vals[i];
				default: ;
			endcase
		end
		cfg_we <= 1'b0;
	endtask

	task automatic test_default_window();
		gaps_on = 1'b0;
		stall_style = STALL_NONE;
		send_pixel(make_pixel(0, 0, 1, 1, 8'hFF, 8'h00, 8'hFF));
		send_pixel(make_pixel(0, 0, 1, 1, 8'h00, 8'hFF, 8'h00));
		send_pixel(make_pixel(0, 0, 1, 1, 8'h03, 8'hFC, 8'h80));
		send_pixel(make_pixel(0, 0, 1, 1, 8'hFC, 8'h03, 8'h7F));
		send_block(318, 5, 321, 5);
		send_block(400, 0, 400, 0);
		send_block(10, 3, 5, 3);
		send_block(2, 9, 2, 4);
		send_retagged(0, 0, 4095, 4095);
		send_retagged(0, 0, 15, 15);
		send_retagged(0, 0, 256, 0);
		send_block(4095, 4095, 4095, 4095);
	endtask

	task automatic test_window_extremes();
		configure(0, 0, 2047, 2047, -2048, -2048);
		send_block(4094, 4095, 4095, 4095);
		send_retagged(0, 0, 4095, 4095);
		configure(2047, 2047, 2047, 2047, 2047, 2047);
		send_block(0, 0, 1, 0);
		send_block(1, 0, 1, 0);
		configure(300, 100, 100, 50, 0, 0);
		send_block(150, 60, 151, 60);
		configure(5, 0, 5, 2047, 0, 0);
		send_block(3, 7, 6, 7);
	endtask

	task automatic test_backpressure();
		configure(0, 0, 319, 239, 10, 20);
		gaps_on = 1'b0;
		stall_style = STALL_NONE;
		hold_req = 1'b1;
		send_block(0, 0, 7, 7);
		send_block(300, 210, 315, 221);
		stall_style = STALL_RANDOM;
		gaps_on = 1'b1;
		send_block(100, 100, 109, 105);
	endtask

	task automatic send_random_shape();
		int pick, w, h, span, l, t, r, b, wlo, wto;
		pick = $urandom_range(0, 99);
		if ($urandom_range(0, 9) == 0) begin
			w = $urandom_range(12, 20);
			h = $urandom_range(12, 20);
		end else begin
			w = $urandom_range(1, 12);
			h = $urandom_range(1, 12);
		end
		wlo = int'(win_l);
		wto = int'(win_t);
		span = (win_r > win_l) ? int'(win_r) - wlo : 0;
		l = wlo - 8 + int'($urandom_range(0, span + 16)) - int'(ofs_x);
		if (l < 0 || l + w - 1 > 4095)
			l = $urandom_range(0, 4096 - w);
		span = (win_b > win_t) ? int'(win_b) - wto : 0;
		t = wto - 8 + int'($urandom_range(0, span + 16)) - int'(ofs_y);
		if (t < 0 || t + h - 1 > 4095)
			t = $urandom_range(0, 4096 - h);
		if (pick < 75) begin
			send_block(l, t, l + w - 1, t + h - 1);
		end else if (pick < 83) begin
			r = $urandom_range(0, l);
			b = ($urandom_range(0, 1) == 1) ? $urandom_range(0, t) : t + h - 1;
			send_block(l, t, r, b);
		end else if (pick < 91) begin
			r = l + $urandom_range(0, 4095 - l);
			b = t + $urandom_range(0, 4095 - t);
			send_retagged(l, t, r, b);
		end else begin
			repeat ($urandom_range(1, 4))
				send_pixel(rand_pixel($urandom_range(0, 4095), $urandom_range(0, 4095),
					$urandom_range(0, 4095), $urandom_range(0, 4095)));
		end
	endtask

	task automatic test_random_blocks();
		int goal, wl, wt, wr, wb, tmp;
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			wl = $urandom_range(0, 1800);
			wr = wl + $urandom_range(0, 247);
			wt = $urandom_range(0, 1800);
			wb = wt + $urandom_range(0, 247);
			if ($urandom_range(0, 9) == 0) begin
				tmp = wl;
				wl = wr;
				wr = tmp;
			end
			configure(wl, wt, wr, wb, int'($urandom_range(0, 4095)) - 2048,
				int'($urandom_range(0, 4095)) - 2048);
			gaps_on = (phase % 2 == 1);
			stall_style = stall_kind_t'(phase % 3);
			goal = items_sent + (ITEM_TARGET - items_sent) / (RANDOM_PHASES - phase);
			while (items_sent < goal)
				send_random_shape();
		end
	endtask

	initial begin
		int run_left;
		bit run_high;
		run_left = 0;
		run_high = 1'b0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				out_stall <= 1'b0;
				hold_req = 1'b0;
			end else begin
				case (stall_style)
					STALL_RANDOM: out_stall <= ($urandom_range(0, 99) < 35);
					STALL_RUNS: begin
						if (run_left == 0) begin
							run_high = ~run_high;
							run_left = run_high ? $urandom_range(1, 8) : $urandom_range(1, 16);
						end
						run_left--;
						out_stall <= run_high;
					end
					default: out_stall <= 1'b0;
				endcase
			end
		end
	end

	always @(posedge clk) begin : check_results
		clip_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t: result of kind %0d with none expected", $time, kind);
			end else begin
				want = pending_results.pop_front();
				check_field("kind", int'(want.kind), int'(kind));
				check_field("out_red", int'(want.red), int'(out_red));
				check_field("out_green", int'(want.green), int'(out_green));
				check_field("out_blue", int'(want.blue), int'(out_blue));
				check_field("dst_x", int'(want.dst_x), int'(dst_x));
				check_field("dst_y", int'(want.dst_y), int'(dst_y));
				check_field("clip_left", int'(want.clip_left), int'(clip_left));
				check_field("clip_top", int'(want.clip_top), int'(clip_top));
				check_field("clip_right", int'(want.clip_right), int'(clip_right));
				check_field("clip_bottom", int'(want.clip_bottom), int'(clip_bottom));
				check_field("pixel_count", int'(want.pixel_count), int'(pixel_count));
				check_field("buffer_select", int'(want.buffer_select),
					int'(buffer_select));
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_WIN_LEFT;
		cfg_data <= '0;
		in_valid <= 1'b0;
		blk_left <= '0;
		blk_top <= '0;
		blk_right <= '0;
		blk_bottom <= '0;
		red <= '0;
		green <= '0;
		blue <= '0;
		win_l = WIN_LEFT_RST;
		win_t = WIN_TOP_RST;
		win_r = WIN_RIGHT_RST;
		win_b = WIN_BOTTOM_RST;
		ofs_x = '0;
		ofs_y = '0;
		blk_col = '0;
		blk_row = '0;
		rect = '{0, 0, 0, 0};
		blk_mode = MODE_IDLE;
		buf_sel = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_default_window();
		test_window_extremes();
		test_backpressure();
		test_random_blocks();
		drain();
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
